@@ hdl/wmg_pkg.sv @@
package wmg_pkg;

    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_HEIGHT = 2'd1,
        ST_NEGRAD = 2'd2,
        ST_SAT    = 2'd3
    } status_t;

    localparam int NUM_W  = 55;
    localparam int DEN_W  = 25;
    localparam int QUO_W  = 32;
    localparam int ROOT_W = QUO_W / 2;

    localparam logic [15:0] GUST_MAX = 16'hFFFF;

    // Payload carried through the long-division stages.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
        status_t          status;
    } div_t;

    // Payload carried through the square-root stages.
    typedef struct packed {
        logic [QUO_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        status_t           status;
    } sqrt_t;

endpackage

@@ hdl/wmg_front.sv @@
module wmg_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [13:0] surface_temp,
    input  logic signed [14:0] freeze_height,
    input  logic        [12:0] surface_mixr,
    input  logic        [12:0] freeze_mixr,
    output logic               out_valid,
    output wmg_pkg::div_t      out_data
);
    import wmg_pkg::*;

    // Stage 1: squares, mixing-ratio term, denominator.
    logic               v1_reg;
    logic        [26:0] tsq1_reg;
    logic        [27:0] hsq1_reg;
    logic signed [15:0] diff1_reg;
    logic        [10:0] smin1_reg;
    logic [DEN_W-1:0]   den1_reg;
    logic               hpos1_reg;

    logic signed [27:0] tprod;
    logic signed [29:0] hprod;
    logic               hpos_next;
    logic signed [15:0] diff_next;

    assign tprod     = surface_temp * surface_temp;
    assign hprod     = freeze_height * freeze_height;
    assign hpos_next = !freeze_height[14] && (freeze_height != 15'sd0);
    assign diff_next = $signed({3'b000, surface_mixr})
                     - $signed({2'b00, freeze_mixr, 1'b0}) - 16'sd3000;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            tsq1_reg  <= tprod[26:0];
            hsq1_reg  <= hprod[27:0];
            diff1_reg <= diff_next;
            smin1_reg <= (surface_mixr < 13'd1200) ? surface_mixr[10:0] : 11'd1200;
            den1_reg  <= hpos_next ? DEN_W'(freeze_height[13:0] * 11'd1920) : DEN_W'(1);
            hpos1_reg <= hpos_next;
        end
    end

    // Stage 2: scale the temperature term, multiply the moisture term by H^2.
    logic               v2_reg;
    logic        [39:0] a2_reg;
    logic signed [43:0] b2_reg;
    logic        [10:0] smin2_reg;
    logic [DEN_W-1:0]   den2_reg;
    logic               hpos2_reg;

    logic        [40:0] a_prod;
    logic signed [44:0] b_prod;

    assign a_prod = tsq1_reg * 14'd10000;
    assign b_prod = diff1_reg * $signed({1'b0, hsq1_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            a2_reg    <= a_prod[39:0];
            b2_reg    <= b_prod[43:0];
            smin2_reg <= smin1_reg;
            den2_reg  <= den1_reg;
            hpos2_reg <= hpos1_reg;
        end
    end

    // Stage 3: the index sum.
    logic               v3_reg;
    logic signed [44:0] i3_reg;
    logic        [10:0] smin3_reg;
    logic [DEN_W-1:0]   den3_reg;
    logic               hpos3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            i3_reg    <= $signed({5'b00000, a2_reg}) + 45'(b2_reg);
            smin3_reg <= smin2_reg;
            den3_reg  <= den2_reg;
            hpos3_reg <= hpos2_reg;
        end
    end

    // Stage 4: numerator and special-case status.
    logic             v4_reg;
    logic [NUM_W-1:0] num4_reg;
    logic [DEN_W-1:0] den4_reg;
    status_t          st4_reg;

    status_t          st_next;
    logic             live_next;

    always_comb begin
        st_next   = ST_NORMAL;
        live_next = 1'b0;
        if (!hpos3_reg) begin
            st_next = ST_HEIGHT;
        end else if (smin3_reg == 11'd0) begin
            st_next = ST_NORMAL;
        end else if (i3_reg[44]) begin
            st_next = ST_NEGRAD;
        end else begin
            live_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            num4_reg <= live_next ? NUM_W'(smin3_reg * i3_reg[43:0]) : '0;
            den4_reg <= live_next ? den3_reg : DEN_W'(1);
            st4_reg  <= st_next;
        end
    end

    // Stage 5: saturation when the quotient reaches 2^32.
    logic             v5_reg;
    div_t             d5_reg;
    logic             sat;

    assign sat = {2'b00, num4_reg} >= {den4_reg, {QUO_W{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
        if (en) begin
            d5_reg.rem    <= sat ? '0 : num4_reg;
            d5_reg.den    <= sat ? DEN_W'(1) : den4_reg;
            d5_reg.quo    <= '0;
            d5_reg.status <= sat ? ST_SAT : st4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = d5_reg;

endmodule

@@ hdl/wmg_div.sv @@
module wmg_div (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  wmg_pkg::div_t  in_data,
    output logic           out_valid,
    output wmg_pkg::sqrt_t out_data
);
    import wmg_pkg::*;

    // One quotient bit per stage, most significant first.
    logic [QUO_W:0] v_reg;
    div_t           d_reg  [QUO_W+1];
    div_t           d_next [QUO_W];

    assign v_reg[0] = in_valid;
    assign d_reg[0] = in_data;

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        localparam int K = QUO_W - 1 - g;
        logic [NUM_W+1:0] trial;

        assign trial = {{QUO_W{1'b0}}, d_reg[g].den} << K;

        always_comb begin
            d_next[g] = d_reg[g];
            if ({2'b00, d_reg[g].rem} >= trial) begin
                d_next[g].rem    = d_reg[g].rem - trial[NUM_W-1:0];
                d_next[g].quo[K] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g+1] <= 1'b0;
            end else if (en) begin
                v_reg[g+1] <= v_reg[g];
            end
            if (en) begin
                d_reg[g+1] <= d_next[g];
            end
        end
    end

    assign out_valid       = v_reg[QUO_W];
    assign out_data.rad    = d_reg[QUO_W].quo;
    assign out_data.root   = '0;
    assign out_data.status = d_reg[QUO_W].status;

endmodule

@@ hdl/wmg_sqrt.sv @@
module wmg_sqrt (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  wmg_pkg::sqrt_t in_data,
    output logic           out_valid,
    output logic [15:0]    gust_speed,
    output wmg_pkg::status_t status
);
    import wmg_pkg::*;

    // Digit-by-digit root: the radicand field keeps q - root^2.
    logic [ROOT_W:0] v_reg;
    sqrt_t           r_reg  [ROOT_W+1];
    sqrt_t           r_next [ROOT_W];

    assign v_reg[0] = in_valid;
    assign r_reg[0] = in_data;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        localparam int K = ROOT_W - 1 - g;
        logic [QUO_W+1:0] trial;

        assign trial = ({{(QUO_W+2-ROOT_W){1'b0}}, r_reg[g].root} << (K + 1))
                     + ((QUO_W+2)'(1) << (2 * K));

        always_comb begin
            r_next[g] = r_reg[g];
            if ({2'b00, r_reg[g].rad} >= trial) begin
                r_next[g].rad     = r_reg[g].rad - trial[QUO_W-1:0];
                r_next[g].root[K] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g+1] <= 1'b0;
            end else if (en) begin
                v_reg[g+1] <= v_reg[g];
            end
            if (en) begin
                r_reg[g+1] <= r_next[g];
            end
        end
    end

    assign out_valid  = v_reg[ROOT_W];
    assign status     = r_reg[ROOT_W].status;
    assign gust_speed = (r_reg[ROOT_W].status == ST_SAT) ? GUST_MAX : r_reg[ROOT_W].root;

endmodule

@@ hdl/wmg_skid.sv @@
module wmg_skid (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [15:0]      in_gust,
    input  wmg_pkg::status_t in_status,
    output logic             room,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [15:0]      m_gust_speed,
    output logic [1:0]       m_status
);
    import wmg_pkg::*;

    logic        out_v_reg;
    logic [15:0] out_g_reg;
    status_t     out_s_reg;
    logic        skid_v_reg;
    logic [15:0] skid_g_reg;
    status_t     skid_s_reg;
    logic        take;

    assign take = m_ready || !out_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (take) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
        end else if (in_valid) begin
            if (take) begin
                out_v_reg <= 1'b1;
            end else begin
                skid_v_reg <= 1'b1;
            end
        end else if (take) begin
            out_v_reg <= 1'b0;
        end
        if (skid_v_reg) begin
            if (take) begin
                out_g_reg <= skid_g_reg;
                out_s_reg <= skid_s_reg;
            end
        end else if (in_valid) begin
            if (take) begin
                out_g_reg <= in_gust;
                out_s_reg <= in_status;
            end else begin
                skid_g_reg <= in_gust;
                skid_s_reg <= in_status;
            end
        end
    end

    assign room         = !skid_v_reg;
    assign m_valid      = out_v_reg;
    assign m_gust_speed = out_g_reg;
    assign m_status     = out_s_reg;

endmodule

@@ hdl/windex_microburst_gust_top.sv @@
// Pipeline: 5 front stages, 32 divider stages, 16 square-root stages, 1 output register.
// Throughput: one transaction per cycle while the skid register is free; each divider and root stage resolves one bit.
// Reset: synchronous active-low aresetn clears all valid bits; data registers are not reset.
module windex_microburst_gust_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [13:0] s_surface_temp,
    input  logic signed [14:0] s_freeze_height,
    input  logic        [12:0] s_surface_mixr,
    input  logic        [12:0] s_freeze_mixr,
    output logic               m_valid,
    input  logic               m_ready,
    output logic        [15:0] m_gust_speed,
    output logic        [1:0]  m_status
);
    import wmg_pkg::*;

    // The whole pipeline advances together whenever the skid register is free.
    // Because the skid register is empty whenever it can accept, an item leaving
    // the pipeline is never dropped, and s_ready comes straight from a flop.
    logic    en;
    logic    front_v;
    div_t    front_d;
    logic    div_v;
    sqrt_t   div_d;
    logic    root_v;
    logic [15:0] root_g;
    status_t root_s;

    assign s_ready = en;

    // Squares, products, the index sum, special cases and the saturation test.
    wmg_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (s_valid),
        .surface_temp  (s_surface_temp),
        .freeze_height (s_freeze_height),
        .surface_mixr  (s_surface_mixr),
        .freeze_mixr   (s_freeze_mixr),
        .out_valid     (front_v),
        .out_data      (front_d)
    );

    // Restoring long division gives floor(num / den), known to be below 2^32.
    wmg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_v),
        .in_data   (front_d),
        .out_valid (div_v),
        .out_data  (div_d)
    );

    // The floor of the root of the floored quotient equals the floor of the exact root.
    wmg_sqrt u_sqrt (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (div_v),
        .in_data    (div_d),
        .out_valid  (root_v),
        .gust_speed (root_g),
        .status     (root_s)
    );

    wmg_skid u_skid (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (root_v),
        .in_gust      (root_g),
        .in_status    (root_s),
        .room         (en),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gust_speed (m_gust_speed),
        .m_status     (m_status)
    );

    // Any result other than a normal one carries a fixed gust value.
    a_zero_on_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_HEIGHT || m_status == ST_NEGRAD) |-> m_gust_speed == 16'd0)
        else $error("fault status with nonzero gust");

    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_SAT |-> m_gust_speed == GUST_MAX)
        else $error("saturated status without full-scale gust");

    // While the pipeline is frozen, the result offered downstream must not be replaced.
    a_hold_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready && !m_ready |=> m_valid && $stable(m_gust_speed) && $stable(m_status))
        else $error("result changed while stalled");

endmodule

@@ test/windex_microburst_gust_checker.sv @@
module windex_microburst_gust_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [13:0] s_surface_temp,
    input  logic signed [14:0] s_freeze_height,
    input  logic        [12:0] s_surface_mixr,
    input  logic        [12:0] s_freeze_mixr,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic        [15:0] m_gust_speed,
    input  logic        [1:0]  m_status,
    output int                 fail_count,
    output int                 pending_gusts
);
    timeunit 1ns;
    timeprecision 1ps;
    import wmg_pkg::*;

    typedef struct packed {
        logic [15:0] gust;
        status_t     status;
    } gust_est_t;

    gust_est_t gust_queue[$];

    function automatic gust_est_t windex_gust(logic signed [13:0] temp,
                                              logic signed [14:0] height,
                                              logic [12:0] smixr,
                                              logic [12:0] fmixr);
        gust_est_t   est;
        longint      t, h, s, f, smin, radicand;
        longint unsigned num, den, root, cand;
        t = temp;
        h = height;
        s = smixr;
        f = fmixr;
        est.gust = '0;
        if (h <= 0) begin
            est.status = ST_HEIGHT;
            return est;
        end
        smin = (s < 1200) ? s : 1200;
        radicand = 10000 * t * t + (s - 2 * f - 3000) * h * h;
        if (smin == 0) begin
            est.status = ST_NORMAL;
            return est;
        end
        if (radicand < 0) begin
            est.status = ST_NEGRAD;
            return est;
        end
        num = smin * radicand;
        den = 1920 * h;
        root = 0;
        for (int b = 16; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand * den <= num) root = cand;
        end
        if (root > 65535) begin
            est.gust = GUST_MAX;
            est.status = ST_SAT;
        end else begin
            est.gust = root[15:0];
            est.status = ST_NORMAL;
        end
        return est;
    endfunction

    // Both fields are compared on every result, and the failure count is
    // updated once per clock with the number of mismatches seen.
    always @(posedge aclk) begin
        gust_est_t want;
        int        errs;
        errs = 0;
        if (!aresetn) begin
            fail_count    <= 0;
            pending_gusts <= 0;
        end else begin
            if (s_valid && s_ready)
                gust_queue.push_back(windex_gust(s_surface_temp, s_freeze_height,
                                                 s_surface_mixr, s_freeze_mixr));
            if (m_valid && m_ready) begin
                if (gust_queue.size() == 0) begin
                    $error("unexpected result gust_speed=%0d status=%0d",
                           m_gust_speed, m_status);
                    errs++;
                end else begin
                    want = gust_queue.pop_front();
                    if (m_gust_speed !== want.gust) begin
                        $error("gust_speed: expected %0d, actual %0d", want.gust,
                               m_gust_speed);
                        errs++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        errs++;
                    end
                end
            end
            fail_count    <= fail_count + errs;
            pending_gusts <= gust_queue.size();
        end
    end
endmodule

@@ test/windex_microburst_gust_top_tb.sv @@
module windex_microburst_gust_top_tb;
    import wmg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_POINTS = 1600;
    localparam int CALM_POINTS   = 200;
    localparam int STALL_LIMIT   = 2000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [13:0] s_surface_temp = '0;
    logic signed [14:0] s_freeze_height = '0;
    logic        [12:0] s_surface_mixr = '0;
    logic        [12:0] s_freeze_mixr = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic        [15:0] m_gust_speed;
    logic        [1:0]  m_status;
    int                 fail_count;
    int                 pending_gusts;
    bit                 calm = 1'b0;
    int                 idle_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    windex_microburst_gust_top u_top (.*);

    windex_microburst_gust_checker u_checker (.*);

    // The receiver accepts for a random burst and now and then stalls for a random
    // burst after it. In the calm tail it simply accepts every cycle.
    initial begin
        int burst;
        @(posedge aclk iff aresetn);
        forever begin
            burst = $urandom_range(1, 15);
            m_ready <= 1'b1;
            repeat (burst) @(posedge aclk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
        end
    end

    // Watchdog: counts consecutive cycles in which no transaction moves on
    // either channel, which catches a hung pipeline or a lost result.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("windex_microburst_gust_top_tb: errors");
            $finish;
        end
    end

    // Drive one grid point and hold it until the block takes the transaction.
    task automatic send_point(logic signed [13:0] temp, logic signed [14:0] height,
                              logic [12:0] smixr, logic [12:0] fmixr);
        s_valid         <= 1'b1;
        s_surface_temp  <= temp;
        s_freeze_height <= height;
        s_surface_mixr  <= smixr;
        s_freeze_mixr   <= fmixr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // Occasionally drop valid for a random burst before the next point.
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    // Random point: mostly physically plausible values, sometimes any bit pattern.
    task automatic send_random_point();
        logic signed [13:0] temp;
        logic signed [14:0] height;
        logic [12:0]        smixr, fmixr;
        temp   = 14'($urandom);
        height = 15'($urandom);
        smixr  = 13'($urandom);
        fmixr  = 13'($urandom);
        case ($urandom_range(0, 9))
            0, 1: ;
            2: smixr = 13'($urandom_range(0, 1300));
            default: begin
                temp   = 14'($signed($urandom_range(0, 12000)) - 6000);
                height = 15'($urandom_range(1, 16000));
                fmixr  = 13'($urandom_range(0, 2500));
                smixr  = 13'($urandom_range(0, 5000));
            end
        endcase
        send_point(temp, height, smixr, fmixr);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed points: field extremes, every status and the special cases.
        send_point(14'sd1000, 15'sd0, 13'd1000, 13'd0);            // height zero
        send_point(14'sd1000, -15'sd1000, 13'd1000, 13'd0);        // height negative
        send_point(-14'sd8192, -15'sd16384, 13'd8191, 13'd8191);  // most negative
        send_point(14'sd0, 15'sd3000, 13'd0, 13'd5000);            // dry surface, I < 0
        send_point(14'sd0, 15'sd3000, 13'd1000, 13'd3000);         // negative radicand
        send_point(14'sd3000, 15'sd3000, 13'd1500, 13'd500);       // typical gust
        send_point(14'sd2500, 15'sd4000, 13'd1200, 13'd600);       // ratio exactly one
        send_point(14'sd8191, 15'sd1, 13'd8191, 13'd0);            // saturation
        send_point(-14'sd6000, 15'sd1, 13'd1200, 13'd0);           // saturation, cold
        send_point(14'sd0, 15'sd16383, 13'd5000, 13'd0);           // tall, moist
        send_point(14'sd8191, 15'sd16383, 13'd8191, 13'd8191);     // all maxima
        send_point(14'sd0, 15'sd1, 13'd1, 13'd0);                  // smallest moist case
        send_point(14'sd6000, 15'sd16000, 13'd1, 13'd0);
        send_point(14'sd1, 15'sd10, 13'd3000, 13'd0);              // tiny positive radicand
        send_point(14'sd0, 15'sd10, 13'd3000, 13'd0);              // radicand exactly zero

        for (int i = 0; i < RANDOM_POINTS; i++) begin
            if (i == RANDOM_POINTS - CALM_POINTS) calm = 1'b1;
            send_random_point();
        end
        s_valid <= 1'b0;

        // Drain the pipeline, then a little extra to catch stray results.
        while (pending_gusts != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        if (fail_count == 0)
            $display("windex_microburst_gust_top_tb: clean");
        else
            $display("windex_microburst_gust_top_tb: errors");
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/wmg_pkg.sv
hdl/wmg_front.sv
hdl/wmg_div.sv
hdl/wmg_sqrt.sv
hdl/wmg_skid.sv
hdl/windex_microburst_gust_top.sv
test/windex_microburst_gust_checker.sv
test/windex_microburst_gust_top_tb.sv
